// File: hdl/sirs_pkg.sv
// shared types and constants for the simpson integral core
package sirs_pkg;
    localparam int MAX_INTERVALS = 1024;
    localparam int CNT_W = 11;

    // ceil(2^44/3): product shifted right by 44 gives the quotient by three
    localparam logic [47:0] RECIP3 = 48'd5864062014806;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_ODD  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDIV,
        S_PT,
        S_SQ,
        S_RDIV,
        S_ACC,
        S_MUL,
        S_D3,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic hdiv_start;
        logic pt_setup;
        logic rdiv_start;
        logic acc;
        logic mul_start;
        logic d3;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic div_done;
        logic last_pt;
        logic mul_done;
    } t_stat;
endpackage

// File: hdl/sirs_ctrl.sv
// controller state machine for the simpson integral core
module sirs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  sirs_pkg::t_stat i_stat,
    output sirs_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    sirs_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= sirs_pkg::S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sirs_pkg::S_IDLE: if (i_start) n_state = sirs_pkg::S_HDIV;
            sirs_pkg::S_HDIV: begin
                if (i_stat.zero) n_state = sirs_pkg::S_DONE;
                else if (i_stat.div_done) n_state = sirs_pkg::S_PT;
            end
            sirs_pkg::S_PT:   n_state = sirs_pkg::S_SQ;
            sirs_pkg::S_SQ:   n_state = sirs_pkg::S_RDIV;
            sirs_pkg::S_RDIV: if (i_stat.div_done) n_state = sirs_pkg::S_ACC;
            sirs_pkg::S_ACC:  n_state = i_stat.last_pt ? sirs_pkg::S_MUL : sirs_pkg::S_PT;
            sirs_pkg::S_MUL:  if (i_stat.mul_done) n_state = sirs_pkg::S_D3;
            sirs_pkg::S_D3:   if (i_stat.mul_done) n_state = sirs_pkg::S_DONE;
            sirs_pkg::S_DONE: n_state = sirs_pkg::S_IDLE;
            default:          n_state = sirs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != sirs_pkg::S_IDLE);
        unique case (r_state)
            sirs_pkg::S_IDLE: begin
                o_cmd.load = i_start;
                o_cmd.hdiv_start = i_start;
            end
            sirs_pkg::S_HDIV: ;
            sirs_pkg::S_PT:   o_cmd.pt_setup = 1'b1;
            sirs_pkg::S_SQ:   o_cmd.rdiv_start = 1'b1;
            sirs_pkg::S_RDIV: ;
            sirs_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                o_cmd.mul_start = i_stat.last_pt;
            end
            sirs_pkg::S_MUL:  o_cmd.d3 = i_stat.mul_done;
            sirs_pkg::S_D3:   ;
            sirs_pkg::S_DONE: o_cmd.fin = 1'b1;
            default: ;
        endcase
    end
endmodule

// File: hdl/sirs_dp.sv
// datapath: step division, sample points, reciprocal, weighted sum, scaling
module sirs_dp (
    input  logic                       i_clk,
    input  logic signed [15:0]         i_lower_bound,
    input  logic signed [15:0]         i_upper_bound,
    input  logic [sirs_pkg::CNT_W-1:0] i_interval_count,
    input  sirs_pkg::t_cmd             i_cmd,
    output sirs_pkg::t_stat            o_stat,
    output logic signed [18:0]         o_integral_value,
    output logic [1:0]                 o_status
);
    logic signed [16:0] r_lo, r_up;
    logic [10:0]  r_n, r_i;
    logic         r_neg;
    logic [37:0]  r_hmag;
    logic [47:0]  r_off;
    logic [19:0]  r_m;
    logic [47:0]  r_sum;
    logic [1:0]   r_status;

    // shared restoring divider, one quotient bit a cycle
    logic [63:0]  r_dq;
    logic [63:0]  r_drem;
    logic [63:0]  r_dvs;
    logic [6:0]   r_dcnt;
    logic         r_dbusy, r_ddone;

    // multiply over 16-bit slices of the second operand, two passes:
    // sum*hmag, then the shifted product by the reciprocal of three
    logic [87:0]  r_prod;
    logic [1:0]   r_mcnt;
    logic         r_mbusy, r_mdone;
    logic         r_scale;
    logic [41:0]  r_sc_in;

    logic [10:0] n_c;
    logic [64:0] trial;
    logic [38:0] den_c;
    logic [47:0] mul_a;
    logic [47:0] mul_b;
    logic signed [48:0] x;
    logic signed [48:0] xt;
    logic [31:0] xabs;
    logic [30:0] fval;
    logic [41:0] mag;
    logic signed [19:0] res;

    assign n_c = (i_interval_count > 11'(sirs_pkg::MAX_INTERVALS)) ?
                 11'(sirs_pkg::MAX_INTERVALS) : i_interval_count;
    assign trial = {1'b0, r_drem[62:0], r_dq[63]} - {1'b0, r_dvs};
    assign den_c = {7'd1, 32'd0} + 39'(r_m) * 39'(r_m);
    assign mul_a = r_scale ? 48'(r_sc_in) : r_sum;
    assign mul_b = r_scale ? sirs_pkg::RECIP3 : 48'(r_hmag);

    // point select: i=0 lower, i=n upper, else lower+/-off
    always_comb begin
        if (r_i == r_n) x = 49'(r_up) <<< 20;
        else if (r_neg) x = (49'(r_lo) <<< 20) - $signed({1'b0, r_off});
        else x = (49'(r_lo) <<< 20) + $signed({1'b0, r_off});
        xt = (x < 0) ? -((-x) >>> 16) : (x >>> 16);
        xabs = (xt < 0) ? 32'(-xt) : 32'(xt);
    end

    assign fval = r_dq[30:0];
    assign mag = r_prod[85:44];
    assign res = r_neg ? -$signed({1'b0, 19'((mag > 42'd262144) ? 42'd262144 : mag)})
                       : $signed({1'b0, 19'((mag > 42'd262143) ? 42'd262143 : mag)});

    always_ff @(posedge i_clk) begin
        r_ddone <= r_dbusy && (r_dcnt == 7'd63) && !i_cmd.hdiv_start && !i_cmd.rdiv_start;
        r_mdone <= r_mbusy && (r_mcnt == 2'd2) && !i_cmd.mul_start && !i_cmd.d3;
        if (i_cmd.load) begin
            r_lo <= 17'(i_lower_bound);
            r_up <= 17'(i_upper_bound);
            r_n <= n_c;
            r_i <= '0;
            r_off <= '0;
            r_status <= (i_interval_count == '0) ? sirs_pkg::ST_ZERO :
                        (n_c[0] ? sirs_pkg::ST_ODD : sirs_pkg::ST_OK);
            r_sum <= '0;
            r_mbusy <= 1'b0;
        end
        if (i_cmd.hdiv_start) begin
            r_dq <= {44'd0, (i_upper_bound < i_lower_bound) ?
                     20'(17'(i_lower_bound) - 17'(i_upper_bound)) :
                     20'(17'(i_upper_bound) - 17'(i_lower_bound))} << 20;
            r_dvs <= 64'(n_c);
            r_drem <= '0;
            r_dcnt <= '0;
            r_dbusy <= 1'b1;
        end else if (i_cmd.rdiv_start) begin
            r_dq <= 64'h4000_0000_0000_0000;
            r_dvs <= 64'(den_c);
            r_drem <= '0;
            r_dcnt <= '0;
            r_dbusy <= 1'b1;
        end else if (r_dbusy) begin
            if (!trial[64]) begin
                r_drem <= trial[63:0];
                r_dq <= {r_dq[62:0], 1'b1};
            end else begin
                r_drem <= {r_drem[62:0], r_dq[63]};
                r_dq <= {r_dq[62:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 7'd1;
            if (r_dcnt == 7'd63) r_dbusy <= 1'b0;
        end
        if (i_cmd.load) r_neg <= i_upper_bound < i_lower_bound;
        if (r_ddone && !i_cmd.pt_setup && r_i == '0 && r_sum == '0 && r_dvs == 64'(r_n))
            r_hmag <= r_dq[37:0];
        if (i_cmd.pt_setup) r_m <= xabs[19:0];
        if (i_cmd.acc) begin
            if (r_i == '0 || r_i == r_n) r_sum <= r_sum + 48'(fval);
            else if (r_i[0]) r_sum <= r_sum + (48'(fval) << 2);
            else r_sum <= r_sum + (48'(fval) << 1);
            r_i <= r_i + 11'd1;
            r_off <= r_off + 48'(r_hmag);
        end
        if (i_cmd.mul_start) begin
            r_prod <= '0;
            r_mcnt <= '0;
            r_mbusy <= 1'b1;
            r_scale <= 1'b0;
        end else if (i_cmd.d3) begin
            r_sc_in <= r_prod[87:46];
            r_prod <= '0;
            r_mcnt <= '0;
            r_mbusy <= 1'b1;
            r_scale <= 1'b1;
        end else if (r_mbusy) begin
            r_prod <= r_prod + ((88'(mul_a) * 88'(mul_b[r_mcnt*16 +: 16]))
                      << (r_mcnt * 16));
            r_mcnt <= r_mcnt + 2'd1;
            if (r_mcnt == 2'd2) r_mbusy <= 1'b0;
        end
        if (i_cmd.fin) begin
            o_integral_value <= (r_status == sirs_pkg::ST_ZERO) ? '0 : res[18:0];
            o_status <= r_status;
        end
    end

    assign o_stat.zero = (r_n == '0);
    assign o_stat.div_done = r_ddone;
    assign o_stat.last_pt = (r_i == r_n);
    assign o_stat.mul_done = r_mdone;
endmodule

// File: hdl/simpson_integral_reciprocal_square_core.sv
// top level of the simpson integral core
// usage: drive bounds and count with i_start high while o_busy is low; that
// beat is taken. o_busy stays high while the item is worked on. the result
// appears on o_integral_value and o_status, with o_valid high for one cycle.
// the step comes from the restoring divider; each of the n+1 sample points
// then takes a square, a reciprocal division on the same divider and an
// accumulate. the final product and the divide by three, done as a multiply
// by a reciprocal, follow on the same multiplier.
// a zero count skips the sample points and goes straight to the result.
// one item at a time; the next start is taken when o_busy falls.
// reset returns the controller to idle and drops o_valid.
// the receiver cannot stall: the result beat lasts one cycle only.
module simpson_integral_reciprocal_square_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_lower_bound,
    input  logic signed [15:0] i_upper_bound,
    input  logic [10:0]        i_interval_count,
    output logic               o_busy,
    output logic               o_valid,
    output logic signed [18:0] o_integral_value,
    output logic [1:0]         o_status
);
    sirs_pkg::t_cmd  cmd;
    sirs_pkg::t_stat stat;
    logic r_valid;

    sirs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_stat(stat), .o_cmd(cmd), .o_busy(o_busy)
    );

    sirs_dp u_dp (
        .i_clk(i_clk), .i_lower_bound(i_lower_bound),
        .i_upper_bound(i_upper_bound), .i_interval_count(i_interval_count),
        .i_cmd(cmd), .o_stat(stat), .o_integral_value(o_integral_value),
        .o_status(o_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else r_valid <= cmd.fin;
    end
    assign o_valid = r_valid;

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid) else $error("valid longer than one cycle");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> !o_busy) else $error("load while busy");
    a_fin_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |=> !o_busy) else $error("not idle after result");
endmodule
